/* hw/rtl/cdeq_pkg.sv */
// Package with shared widths, defaults and codes for the circular deque.
package cdeq_pkg;

    localparam int DEPTH_DEFAULT      = 8;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DOUT_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_REAR  = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

/* hw/rtl/cdeq_if.sv */
// Valid/ready channel interfaces for the deque requests and results.
interface cdeq_in_if;
    logic                                valid;
    logic                                ready;
    logic [cdeq_pkg::MODE_W-1:0]         mode;
    logic signed [cdeq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface cdeq_out_if;
    logic                               valid;
    logic                               ready;
    logic [cdeq_pkg::STATUS_W-1:0]      status;
    logic signed [cdeq_pkg::DOUT_W-1:0] data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink (input valid, input status, input data_out, output ready);
endinterface

/* hw/rtl/cdeq_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/circular_double_ended_queue_core.sv */
// Top level of the circular double-ended queue with its index control.
//
//  Channel | Direction | Payload              | Handshake
//  i_in    | request   | mode, value          | valid / ready
//  o_out   | result    | status, data_out     | valid / ready
//
// The index update and slot access happen at acceptance; the result is then
// formed from the RAM's registered read data once the result register is
// free. Reset leaves the queue empty with both indices at zero.
// The result register holds a finished item while the sink stalls; a
// pending item then waits and no new item is accepted.
module circular_double_ended_queue_core #(
    parameter int DEPTH      = cdeq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cdeq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cdeq_in_if.sink      i_in,
    cdeq_out_if.source   o_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_rear, n_rear;
    logic             r_empty, n_empty;
    logic             r_busy, n_busy;
    logic             r_pend_rd, n_pend_rd;
    logic [cdeq_pkg::STATUS_W-1:0] r_pend_status, n_pend_status;
    logic             r_out_valid, n_out_valid;
    logic [cdeq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [cdeq_pkg::DOUT_W-1:0]   r_data, n_data;

    logic                  ram_en;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic             in_fire;
    logic             full;
    logic [IDX_W-1:0] front_next, front_prev, rear_next, rear_prev;

    cdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready     = !r_busy;
    assign in_fire        = i_in.valid && !r_busy;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.data_out = r_data;

    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign rear_next  = (r_rear == LAST_IDX) ? '0 : r_rear + 1'b1;
    assign rear_prev  = (r_rear == '0) ? LAST_IDX : r_rear - 1'b1;
    assign full       = !r_empty && (rear_next == r_front);
    assign ram_wdata  = DATA_WIDTH'(i_in.value);

    always_comb begin
        n_front       = r_front;
        n_rear        = r_rear;
        n_empty       = r_empty;
        n_busy        = r_busy;
        n_pend_rd     = r_pend_rd;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_data        = r_data;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = r_front;

        if (r_busy && (!r_out_valid || o_out.ready)) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_status    = r_pend_status;
            n_data      = r_pend_rd ? cdeq_pkg::DOUT_W'(ram_rdata) : '0;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (in_fire) begin
            n_busy        = 1'b1;
            n_pend_rd     = 1'b0;
            n_pend_status = cdeq_pkg::ST_DONE;
            case (cdeq_pkg::t_mode'(i_in.mode))
                cdeq_pkg::MODE_PUSH_FRONT, cdeq_pkg::MODE_PUSH_REAR: begin
                    if (full) begin
                        n_pend_status = cdeq_pkg::ST_FULL;
                    end else begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                        if (r_empty) begin
                            n_front  = '0;
                            n_rear   = '0;
                            n_empty  = 1'b0;
                            ram_addr = '0;
                        end else if (i_in.mode == cdeq_pkg::MODE_PUSH_FRONT) begin
                            n_front  = front_prev;
                            ram_addr = front_prev;
                        end else begin
                            n_rear   = rear_next;
                            ram_addr = rear_next;
                        end
                    end
                end
                cdeq_pkg::MODE_POP_FRONT, cdeq_pkg::MODE_POP_REAR: begin
                    if (r_empty) begin
                        n_pend_status = cdeq_pkg::ST_EMPTY;
                    end else begin
                        ram_en    = 1'b1;
                        n_pend_rd = 1'b1;
                        ram_addr  = (i_in.mode == cdeq_pkg::MODE_POP_FRONT) ? r_front : r_rear;
                        if (r_front == r_rear) begin
                            n_empty = 1'b1;
                            n_front = '0;
                            n_rear  = '0;
                        end else if (i_in.mode == cdeq_pkg::MODE_POP_FRONT) begin
                            n_front = front_next;
                        end else begin
                            n_rear = rear_prev;
                        end
                    end
                end
                cdeq_pkg::MODE_PEEK_FRONT, cdeq_pkg::MODE_PEEK_REAR: begin
                    if (r_empty) begin
                        n_pend_status = cdeq_pkg::ST_EMPTY;
                    end else begin
                        ram_en    = 1'b1;
                        n_pend_rd = 1'b1;
                        ram_addr  = (i_in.mode == cdeq_pkg::MODE_PEEK_FRONT) ? r_front : r_rear;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_pend_rd     <= n_pend_rd;
        r_pend_status <= n_pend_status;
        r_status      <= n_status;
        r_data        <= n_data;
    end

    a_empty_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0 && r_rear == '0))
        else $error("Empty queue with nonzero index.");

    a_fire_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_busy)
        else $error("Accepted item did not become pending.");

    a_pending_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_out_valid) |=> (!r_busy && r_out_valid))
        else $error("Pending item not moved to the result register.");

    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != cdeq_pkg::ST_DONE) |-> (r_data == '0))
        else $error("Refused item carries nonzero data.");

endmodule

/* tb/circular_double_ended_queue_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circular double-ended queue core, with an in-line deque mirror.
module circular_double_ended_queue_core_tb;

    localparam int DEPTH   = cdeq_pkg::DEPTH_DEFAULT;
    localparam int MODE_W  = cdeq_pkg::MODE_W;
    localparam int VALUE_W = cdeq_pkg::VALUE_W;
    localparam int DOUT_W  = cdeq_pkg::DOUT_W;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int RANDOM_OPS   = 800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_FILL   = 0;
    localparam int PHASE_DRAIN  = 1;
    localparam int PHASE_MIXED  = 2;

    typedef struct {
        cdeq_pkg::t_status         status;
        logic signed [DOUT_W-1:0]  data;
    } t_reply;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        cdeq_pkg::t_status         status;
        logic signed [DOUT_W-1:0]  data;
    } t_row;

    t_row directed_ops [24] = '{
        '{cdeq_pkg::MODE_POP_FRONT,  32'sh00000000, 1'b1, cdeq_pkg::ST_EMPTY, 32'sh00000000},
        '{cdeq_pkg::MODE_POP_REAR,   32'shFFFFFFFF, 1'b1, cdeq_pkg::ST_EMPTY, 32'sh00000000},
        '{cdeq_pkg::MODE_PEEK_FRONT, 32'sh00000000, 1'b1, cdeq_pkg::ST_EMPTY, 32'sh00000000},
        '{cdeq_pkg::MODE_PEEK_REAR,  32'sh7FFFFFFF, 1'b1, cdeq_pkg::ST_EMPTY, 32'sh00000000},
        '{MODE_SPARE_LO,             32'sh12345678, 1'b1, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{MODE_SPARE_HI,             32'shFFFFFFFF, 1'b1, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'sh7FFFFFFF, 1'b1, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PEEK_FRONT, 32'sh00000000, 1'b1, cdeq_pkg::ST_DONE,  32'sh7FFFFFFF},
        '{cdeq_pkg::MODE_POP_REAR,   32'sh00000000, 1'b1, cdeq_pkg::ST_DONE,  32'sh7FFFFFFF},
        '{cdeq_pkg::MODE_PEEK_REAR,  32'sh00000000, 1'b1, cdeq_pkg::ST_EMPTY, 32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_REAR,  32'sh80000000, 1'b1, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'shFFFFFFFF, 1'b1, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_REAR,  32'sh00000000, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'sh55555555, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_REAR,  32'shAAAAAAAA, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'sh00000001, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_REAR,  32'sh12345678, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'shFEDCBA98, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_REAR,  32'sh00000001, 1'b1, cdeq_pkg::ST_FULL,  32'sh00000000},
        '{cdeq_pkg::MODE_PUSH_FRONT, 32'sh00000002, 1'b1, cdeq_pkg::ST_FULL,  32'sh00000000},
        '{cdeq_pkg::MODE_PEEK_FRONT, 32'sh00000000, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_PEEK_REAR,  32'sh00000000, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_POP_FRONT,  32'sh00000000, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000},
        '{cdeq_pkg::MODE_POP_REAR,   32'sh00000000, 1'b0, cdeq_pkg::ST_DONE,  32'sh00000000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdeq_in_if  req_if ();
    cdeq_out_if rsp_if ();

    circular_double_ended_queue_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (cdeq_pkg::DATA_WIDTH_DEFAULT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (rsp_if.source)
    );

    logic signed [VALUE_W-1:0] mirror_slots [DEPTH];
    int                        head_at;
    int                        tail_at;
    bit                        mirror_empty;

    t_reply due_replies [$];
    int     fail_count  = 0;
    int     idle_cycles = 0;
    int     burst_left  = 0;
    int     stall_cycle = 0;
    int     stall_style = 0;

    always #5 i_clk = ~i_clk;

    function automatic t_reply deque_apply(logic [MODE_W-1:0] op,
                                           logic signed [VALUE_W-1:0] word);
        t_reply r;
        bit     full;
        int     at;
        r.status = cdeq_pkg::ST_DONE;
        r.data   = '0;
        full = !mirror_empty && ((tail_at + 1) % DEPTH == head_at);
        case (op)
            cdeq_pkg::MODE_PUSH_FRONT, cdeq_pkg::MODE_PUSH_REAR: begin
                if (full) begin
                    r.status = cdeq_pkg::ST_FULL;
                end else if (mirror_empty) begin
                    head_at = 0;
                    tail_at = 0;
                    mirror_empty = 1'b0;
                    mirror_slots[0] = word;
                end else if (op == cdeq_pkg::MODE_PUSH_FRONT) begin
                    head_at = (head_at + DEPTH - 1) % DEPTH;
                    mirror_slots[head_at] = word;
                end else begin
                    tail_at = (tail_at + 1) % DEPTH;
                    mirror_slots[tail_at] = word;
                end
            end
            cdeq_pkg::MODE_POP_FRONT, cdeq_pkg::MODE_POP_REAR: begin
                if (mirror_empty) begin
                    r.status = cdeq_pkg::ST_EMPTY;
                end else begin
                    at = (op == cdeq_pkg::MODE_POP_FRONT) ? head_at : tail_at;
                    r.data = mirror_slots[at];
                    if (head_at == tail_at) begin
                        mirror_empty = 1'b1;
                        head_at = 0;
                        tail_at = 0;
                    end else if (op == cdeq_pkg::MODE_POP_FRONT) begin
                        head_at = (head_at + 1) % DEPTH;
                    end else begin
                        tail_at = (tail_at + DEPTH - 1) % DEPTH;
                    end
                end
            end
            cdeq_pkg::MODE_PEEK_FRONT, cdeq_pkg::MODE_PEEK_REAR: begin
                if (mirror_empty) begin
                    r.status = cdeq_pkg::ST_EMPTY;
                end else begin
                    r.data = mirror_slots[(op == cdeq_pkg::MODE_PEEK_FRONT) ? head_at : tail_at];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [MODE_W-1:0] pick_op(int phase);
        int roll;
        int push_pct;
        int peek_pct;
        bit rear;
        roll = $urandom_range(0, 99);
        rear = $urandom_range(0, 1);
        case (phase)
            PHASE_FILL: begin
                push_pct = 60;
                peek_pct = 80;
            end
            PHASE_DRAIN: begin
                push_pct = 20;
                peek_pct = 35;
            end
            default: begin
                push_pct = 40;
                peek_pct = 60;
            end
        endcase
        if (roll < push_pct) begin
            return rear ? cdeq_pkg::MODE_PUSH_REAR : cdeq_pkg::MODE_PUSH_FRONT;
        end else if (roll < peek_pct) begin
            return rear ? cdeq_pkg::MODE_PEEK_REAR : cdeq_pkg::MODE_PEEK_FRONT;
        end else if (roll < 98) begin
            return rear ? cdeq_pkg::MODE_POP_REAR : cdeq_pkg::MODE_POP_FRONT;
        end
        return rear ? MODE_SPARE_HI : MODE_SPARE_LO;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            3: return 32'shFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [MODE_W-1:0] op, logic signed [VALUE_W-1:0] word,
                             bit typed, cdeq_pkg::t_status typed_status,
                             logic signed [DOUT_W-1:0] typed_data);
        int     gap;
        t_reply r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.mode  <= op;
        req_if.value <= word;
        do @(posedge i_clk); while (!req_if.ready);
        r = deque_apply(op, word);
        if (typed) begin
            r.status = typed_status;
            r.data   = typed_data;
        end
        due_replies.push_back(r);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0) begin
            stall_style <= $urandom_range(0, 3);
        end
        case (stall_style)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 1);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= (stall_cycle[2:0] != 3'd5) && (stall_cycle[3:0] != 4'd9);
        endcase
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_replies.size() == 0) begin
                    $error("reply with nothing outstanding: status %0d, data_out %0d",
                           rsp_if.status, rsp_if.data_out);
                    fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_if.status);
                        fail_count++;
                    end
                    if (rsp_if.data_out !== want.data) begin
                        $error("data_out mismatch: expected %0d, actual %0d",
                               want.data, rsp_if.data_out);
                        fail_count++;
                    end
                end
            end
            if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int taken;
        int phase;
        logic [MODE_W-1:0] op;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = cdeq_pkg::MODE_PUSH_FRONT;
        req_if.value  = '0;
        head_at       = 0;
        tail_at       = 0;
        mirror_empty  = 1'b1;
        foreach (mirror_slots[k]) mirror_slots[k] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_ops[k]) begin
            send_item(directed_ops[k].mode, directed_ops[k].value, directed_ops[k].typed,
                      directed_ops[k].status, directed_ops[k].data);
        end

        taken = 0;
        phase = PHASE_FILL;
        while (taken < RANDOM_OPS) begin
            if (taken % 40 == 0) begin
                phase = $urandom_range(PHASE_FILL, PHASE_MIXED);
            end
            op = pick_op(phase);
            send_item(op, pick_word(), 1'b0, cdeq_pkg::ST_DONE, '0);
            if (op != MODE_SPARE_LO && op != MODE_SPARE_HI) begin
                taken++;
            end
        end
        req_if.valid <= 1'b0;

        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_replies.size() != 0) begin
            $error("%0d replies never arrived", due_replies.size());
        end
        if (fail_count == 0 && due_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/cdeq_pkg.sv
hw/rtl/cdeq_if.sv
hw/rtl/cdeq_ram.sv
hw/rtl/circular_double_ended_queue_core.sv
tb/circular_double_ended_queue_core_tb.sv
